@@ rtl/assert_macros.svh @@
// Assertion macros shared by the queue and engine RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

@@ rtl/sha256_pkg.sv @@
package sha256_pkg;

    typedef struct packed {
        logic [7:0] message_byte;
        logic       has_byte;
        logic       is_last;
    } t_in_word;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_word;

    // Command from the front part to the compression engine.
    typedef struct packed {
        logic [511:0] block;
        logic         finish;
    } t_cmd;

    localparam int QueueDepth = 2;

    localparam logic [255:0] InitHash = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [7:0] PadByte = 8'h80;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf; 6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98; 6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

@@ rtl/sha256_front.sv @@
module sha256_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha256_pkg::t_in_word i_in_word,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output sha256_pkg::t_cmd    o_cmd,
    output logic                o_cmd_valid,
    input  logic                i_cmd_ready
);

    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StPadA = 2'd1;
    localparam logic [1:0] StPadB = 2'd2;

    logic [1:0]   r_state, n_state;
    logic [511:0] r_buf;
    logic [60:0]  r_count;
    logic [5:0]   r_pos;
    logic [63:0]  r_bits;
    logic         r_two;

    logic [60:0]  count_inc;
    logic [511:0] buf_byte;
    logic [511:0] pad_buf;
    logic [511:0] len_buf;
    logic         take;
    logic         full;
    logic         cmd_load;

    assign count_inc = r_count + 61'd1;
    assign take = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == StIdle) && !(o_cmd_valid && !i_cmd_ready);

    always_comb begin
        buf_byte = r_buf;
        buf_byte[511 - 8 * r_count[5:0] -: 8] = i_in_word.message_byte;
    end

    always_comb begin
        pad_buf = r_buf;
        for (int j = 0; j < 64; j++) begin
            if (6'(j) == r_pos) begin
                pad_buf[511 - 8 * j -: 8] = sha256_pkg::PadByte;
            end else if (6'(j) > r_pos) begin
                pad_buf[511 - 8 * j -: 8] = 8'h00;
            end
        end
    end

    always_comb begin
        len_buf = r_two ? 512'd0 : pad_buf;
        len_buf[63:0] = r_bits;
    end

    assign full = i_in_word.has_byte && (count_inc[5:0] == 6'd0);
    assign n_state = r_state;

    assign cmd_load = (r_state == StIdle && take && full)
        || (r_state == StPadA && (!o_cmd_valid || i_cmd_ready) && r_pos >= 6'd56)
        || (r_state == StPadB && (!o_cmd_valid || i_cmd_ready));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= StIdle;
            r_count     <= '0;
            o_cmd_valid <= 1'b0;
        end else begin
            if (cmd_load) begin
                o_cmd_valid <= 1'b1;
            end else if (i_cmd_ready) begin
                o_cmd_valid <= 1'b0;
            end
            case (n_state)
                StIdle: begin
                    if (take) begin
                        if (i_in_word.has_byte) begin
                            r_buf   <= buf_byte;
                            r_count <= count_inc;
                        end
                        if (full) begin
                            o_cmd.block  <= buf_byte;
                            o_cmd.finish <= 1'b0;
                        end
                        if (i_in_word.is_last) begin
                            r_state <= StPadA;
                            if (i_in_word.has_byte) begin
                                r_pos  <= count_inc[5:0];
                                r_bits <= {count_inc, 3'b000};
                            end else begin
                                r_pos  <= r_count[5:0];
                                r_bits <= {r_count, 3'b000};
                            end
                        end
                    end
                end
                StPadA: begin
                    if (!o_cmd_valid || i_cmd_ready) begin
                        if (r_pos >= 6'd56) begin
                            o_cmd.block  <= pad_buf;
                            o_cmd.finish <= 1'b0;
                            r_two        <= 1'b1;
                            r_state      <= StPadB;
                        end else begin
                            r_two   <= 1'b0;
                            r_state <= StPadB;
                        end
                    end
                end
                StPadB: begin
                    if (!o_cmd_valid || i_cmd_ready) begin
                        o_cmd.block  <= len_buf;
                        o_cmd.finish <= 1'b1;
                        r_count      <= '0;
                        r_state      <= StIdle;
                    end
                end
                default: r_state <= StIdle;
            endcase
        end
    end

endmodule

@@ rtl/sha256_queue.sv @@
module sha256_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sha256_pkg::t_cmd i_cmd,
    input  logic             i_valid,
    output logic             o_ready,
    output sha256_pkg::t_cmd o_cmd,
    output logic             o_valid,
    input  logic             i_ready
);

    `include "assert_macros.svh"

    localparam int PtrW = $clog2(sha256_pkg::QueueDepth);

    sha256_pkg::t_cmd r_mem [sha256_pkg::QueueDepth];
    logic [PtrW-1:0]  r_wr, r_rd;
    logic [PtrW:0]    r_fill;
    logic             push, pop;

    assign o_ready = (r_fill != PtrW'(0) + (PtrW + 1)'(sha256_pkg::QueueDepth));
    assign o_valid = (r_fill != '0);
    assign o_cmd   = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PtrW'(sha256_pkg::QueueDepth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PtrW'(sha256_pkg::QueueDepth - 1)) ? '0 : r_rd + 1'b1;
            end
            r_fill <= r_fill + (PtrW + 1)'(push) - (PtrW + 1)'(pop);
        end
    end

    `ASSERT_IMPLIES(a_fill_range, i_clk, i_rst_n, 1'b1,
        r_fill <= (PtrW + 1)'(sha256_pkg::QueueDepth))
    `ASSERT_NEXT(a_fill_push, i_clk, i_rst_n, push && !pop, r_fill == $past(r_fill) + 1'b1)
    `ASSERT_NEXT(a_fill_pop, i_clk, i_rst_n, pop && !push, r_fill == $past(r_fill) - 1'b1)

endmodule

@@ rtl/sha256_engine.sv @@
module sha256_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sha256_pkg::t_cmd     i_cmd,
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_ready,
    output sha256_pkg::t_out_word o_out_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready
);

    `include "assert_macros.svh"

    localparam logic [1:0] StIdle  = 2'd0;
    localparam logic [1:0] StRound = 2'd1;
    localparam logic [1:0] StAdd   = 2'd2;
    localparam logic [1:0] StOut   = 2'd3;

    logic [1:0]   r_state;
    logic [5:0]   r_round;
    logic [2:0]   r_idx;
    logic         r_finish;
    logic [31:0]  r_h [8];
    logic [31:0]  r_v [8];
    logic [31:0]  r_w [16];

    logic [31:0]  w15, w2, sg0, sg1, wnew, wr, big1, ch, t1, big0, maj, t2;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    assign w15  = r_w[1];
    assign w2   = r_w[14];
    assign sg0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
    assign sg1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    assign wnew = r_w[0] + sg0 + r_w[9] + sg1;
    assign wr   = r_w[0];
    assign big1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
    assign ch   = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign t1   = r_v[7] + big1 + ch + sha256_pkg::round_k(r_round) + wr;
    assign big0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
    assign maj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t2   = big0 + maj;

    assign o_cmd_ready = (r_state == StIdle);
    assign o_out_valid = (r_state == StOut);
    assign o_out_word.digest_word = r_h[r_idx];
    assign o_out_word.word_index  = r_idx;
    assign o_out_word.last_word   = (r_idx == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            for (int j = 0; j < 8; j++) begin
                r_h[j] <= sha256_pkg::InitHash[255 - 32 * j -: 32];
            end
        end else begin
            case (r_state)
                StIdle: begin
                    if (i_cmd_valid) begin
                        for (int j = 0; j < 16; j++) begin
                            r_w[j] <= i_cmd.block[511 - 32 * j -: 32];
                        end
                        for (int j = 0; j < 8; j++) begin
                            r_v[j] <= r_h[j];
                        end
                        r_finish <= i_cmd.finish;
                        r_round  <= '0;
                        r_state  <= StRound;
                    end
                end
                StRound: begin
                    for (int j = 0; j < 15; j++) begin
                        r_w[j] <= r_w[j + 1];
                    end
                    r_w[15] <= wnew;
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) begin
                        r_state <= StAdd;
                    end
                end
                StAdd: begin
                    for (int j = 0; j < 8; j++) begin
                        r_h[j] <= r_h[j] + r_v[j];
                    end
                    r_idx   <= '0;
                    r_state <= r_finish ? StOut : StIdle;
                end
                StOut: begin
                    if (i_out_ready) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            for (int j = 0; j < 8; j++) begin
                                r_h[j] <= sha256_pkg::InitHash[255 - 32 * j -: 32];
                            end
                            r_state <= StIdle;
                        end
                    end
                end
                default: r_state <= StIdle;
            endcase
        end
    end

    `ASSERT_IMPLIES(a_no_take_busy, i_clk, i_rst_n, r_state != StIdle, !o_cmd_ready)
    `ASSERT_NEXT(a_round_end, i_clk, i_rst_n, r_state == StRound && r_round == 6'd63,
        r_state == StAdd)
    `ASSERT_NEXT(a_out_done, i_clk, i_rst_n,
        o_out_valid && i_out_ready && o_out_word.last_word, r_state == StIdle)

endmodule

@@ rtl/sha256_message_hasher_core.sv @@
// Each 64-byte block goes through the compression engine as load, 64 rounds, add.
// Bytes are taken one per cycle; input stalls when a finished block waits on a full
// two-entry block queue, and after an ending item while padding is built. Bytes of a
// new block can be taken while the engine compresses the last one. An ending item
// adds one or two padding blocks; the eight digest words then go out one per cycle
// while the receiver is ready. Reset is synchronous, active low, and restores the hash.
module sha256_message_hasher_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sha256_pkg::t_in_word  i_in_word,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output sha256_pkg::t_out_word o_out_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready
);

    sha256_pkg::t_cmd f_cmd, q_cmd;
    logic f_valid, f_ready, q_valid, q_ready;

    sha256_front u_front (
        .i_clk, .i_rst_n, .i_in_word, .i_in_valid, .o_in_ready,
        .o_cmd(f_cmd), .o_cmd_valid(f_valid), .i_cmd_ready(f_ready));

    sha256_queue u_queue (
        .i_clk, .i_rst_n, .i_cmd(f_cmd), .i_valid(f_valid), .o_ready(f_ready),
        .o_cmd(q_cmd), .o_valid(q_valid), .i_ready(q_ready));

    sha256_engine u_engine (
        .i_clk, .i_rst_n, .i_cmd(q_cmd), .i_cmd_valid(q_valid), .o_cmd_ready(q_ready),
        .o_out_word, .o_out_valid, .i_out_ready);

endmodule

@@ tb/tb_sha256_message_hasher_core.sv @@
`timescale 1ns / 100ps

module tb_sha256_message_hasher_core;

    localparam int StallHold = 600;
    localparam logic [255:0] StartHash = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    logic                  i_clk;
    logic                  i_rst_n;
    sha256_pkg::t_in_word  i_in_word;
    logic                  i_in_valid;
    logic                  o_in_ready;
    sha256_pkg::t_out_word o_out_word;
    logic                  o_out_valid;
    logic                  i_out_ready;

    sha256_message_hasher_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_word (o_out_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready)
    );

    sha256_pkg::t_in_word  pending_bytes[$];
    sha256_pkg::t_out_word expected_digest[$];
    logic [31:0] hash_state[8];
    logic [7:0]  msg_block[64];
    logic [60:0] msg_len;
    int  mismatch_count;
    bit  calm_phase;
    bit  hold_receiver;
    int  send_gap;
    int  recv_gap;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] k_const(int r);
        logic [31:0] k[64] = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
            32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
            32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
            32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
            32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[r];
    endfunction

    task automatic compress_block();
        logic [31:0] w[64];
        logic [31:0] v[8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int j = 0; j < 16; j++) begin
            w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
        end
        for (int j = 16; j < 64; j++) begin
            w[j] = w[j-16] + w[j-7]
                 + (rotr(w[j-15], 7) ^ rotr(w[j-15], 18) ^ (w[j-15] >> 3))
                 + (rotr(w[j-2], 17) ^ rotr(w[j-2], 19) ^ (w[j-2] >> 10));
        end
        for (int j = 0; j < 8; j++) begin
            v[j] = hash_state[j];
        end
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_const(r) + w[r];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int j = 7; j > 0; j--) begin
                v[j] = v[j-1];
            end
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++) begin
            hash_state[j] = hash_state[j] + v[j];
        end
    endtask

    task automatic reset_hash();
        for (int j = 0; j < 8; j++) begin
            hash_state[j] = StartHash[255 - 32*j -: 32];
        end
        msg_len = '0;
    endtask

    task automatic hash_word(sha256_pkg::t_in_word w);
        int pos;
        logic [63:0] bits;
        sha256_pkg::t_out_word o;
        if (w.has_byte) begin
            msg_block[msg_len[5:0]] = w.message_byte;
            msg_len = msg_len + 1'b1;
            if (msg_len[5:0] == 0) begin
                compress_block();
            end
        end
        if (w.is_last) begin
            pos = msg_len[5:0];
            msg_block[pos] = 8'h80;
            for (int j = pos + 1; j < 64; j++) begin
                msg_block[j] = 8'h00;
            end
            if (pos >= 56) begin
                compress_block();
                for (int j = 0; j < 64; j++) begin
                    msg_block[j] = 8'h00;
                end
            end
            bits = {msg_len, 3'b000};
            for (int j = 0; j < 8; j++) begin
                msg_block[56 + j] = bits[63 - 8*j -: 8];
            end
            compress_block();
            for (int j = 0; j < 8; j++) begin
                o.digest_word = hash_state[j];
                o.word_index  = 3'(j);
                o.last_word   = (j == 7);
                expected_digest.push_back(o);
            end
            reset_hash();
        end
    endtask

    function automatic sha256_pkg::t_in_word make_word(logic [7:0] b, logic hb, logic last);
        sha256_pkg::t_in_word w;
        w.message_byte = b;
        w.has_byte     = hb;
        w.is_last      = last;
        return w;
    endfunction

    task automatic queue_message(int len, bit end_with_byte);
        for (int j = 0; j < len; j++) begin
            pending_bytes.push_back(make_word(8'($urandom), 1'b1,
                                              end_with_byte && j == len - 1));
            if ($urandom_range(0, 15) == 0) begin
                pending_bytes.push_back(make_word(8'($urandom), 1'b0, 1'b0));
            end
        end
        if (!end_with_byte || len == 0) begin
            pending_bytes.push_back(make_word(8'($urandom), 1'b0, 1'b1));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_word  <= '0;
            send_gap   <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                hash_word(i_in_word);
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    i_in_valid <= 1'b0;
                    send_gap   <= send_gap - 1;
                end else if (pending_bytes.size() > 0) begin
                    i_in_word  <= pending_bytes.pop_front();
                    i_in_valid <= 1'b1;
                    if (!calm_phase && $urandom_range(0, 7) == 0) begin
                        send_gap <= $urandom_range(1, 14);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_gap    <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_digest.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected digest word %h", o_out_word);
                    end
                end else begin
                    if (o_out_word !== expected_digest[0]) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display({"digest mismatch: expected %h idx %0d last %b,",
                                      " got %h idx %0d last %b"},
                                     expected_digest[0].digest_word,
                                     expected_digest[0].word_index,
                                     expected_digest[0].last_word, o_out_word.digest_word,
                                     o_out_word.word_index, o_out_word.last_word);
                        end
                    end
                    void'(expected_digest.pop_front());
                end
            end
            if (hold_receiver) begin
                i_out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                i_out_ready <= 1'b0;
                recv_gap    <= recv_gap - 1;
            end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                recv_gap    <= $urandom_range(0, 13);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        mismatch_count = 0;
        calm_phase     = 0;
        hold_receiver  = 0;
        for (int j = 0; j < 64; j++) begin
            msg_block[j] = 8'h00;
        end
        reset_hash();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        pending_bytes.push_back(make_word(8'hff, 1'b0, 1'b1));
        pending_bytes.push_back(make_word(8'h00, 1'b0, 1'b0));
        pending_bytes.push_back(make_word(8'hff, 1'b0, 1'b0));
        pending_bytes.push_back(make_word(8'h00, 1'b1, 1'b1));
        pending_bytes.push_back(make_word(8'hff, 1'b1, 1'b0));
        pending_bytes.push_back(make_word(8'h55, 1'b1, 1'b0));
        pending_bytes.push_back(make_word(8'haa, 1'b0, 1'b1));
        wait (pending_bytes.size() == 0);

        // A full block followed by a tail of 56 bytes needs two padding blocks; the short
        // messages after it fill the block queue while the receiver is held off.
        hold_receiver = 1;
        queue_message(120, 1);
        queue_message(2, 0);
        queue_message(0, 1);
        queue_message(1, 1);
        queue_message(0, 0);
        queue_message(3, 1);
        repeat (StallHold) @(posedge i_clk);
        hold_receiver = 0;
        wait (pending_bytes.size() == 0);

        for (int m = 0; m < 2; m++) begin
            queue_message($urandom_range(0, 6), $urandom_range(0, 1));
        end
        wait (pending_bytes.size() == 0);
        calm_phase = 1;
        for (int m = 0; m < 2; m++) begin
            queue_message($urandom_range(0, 6), $urandom_range(0, 1));
        end
        wait (pending_bytes.size() == 0);
        @(posedge i_clk);
        while (i_in_valid) @(posedge i_clk);
        wait (expected_digest.size() == 0);
        repeat (300) @(posedge i_clk);
        if (mismatch_count == 0 && expected_digest.size() == 0) begin
            $display("sha256_message_hasher_core verification clean");
        end else begin
            $display("sha256_message_hasher_core verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("sha256_message_hasher_core verification failed");
        $finish;
    end

endmodule
